FILE: rtl/core/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the stereo biquad with silence gate.
// ----------------------------------------------------------------------------
`default_nettype none

package sbq_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int COEF_WIDTH         = 20;
    localparam int QUIET_WIDTH        = 23;
    localparam int LIMIT_WIDTH        = 16;
    localparam int CFG_DATA_W         = 32;
    localparam int CFG_ADDR_W         = 5;
    localparam int REG_IDX_W          = 3;

    // register index, byte address is 4 * index
    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_B0       = 3'd0,
        REG_COEF_B1       = 3'd1,
        REG_COEF_B2       = 3'd2,
        REG_COEF_A1       = 3'd3,
        REG_COEF_A2       = 3'd4,
        REG_QUIET_LEVEL   = 3'd5,
        REG_SETTLE_LIMIT  = 3'd6,
        REG_STEREO_ENABLE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } t_coefs;

    // per-sample decision from the silence gate
    typedef struct packed {
        logic run;       // filter runs and history advances
        logic zero_out;  // result samples forced to zero
    } t_step_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/sbq_cfg.sv
// ----------------------------------------------------------------------------
// sbq_cfg
// APB register file holding coefficients and silence gate settings.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sbq_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sbq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [sbq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output sbq_pkg::t_coefs                     o_coefs,
    output logic [sbq_pkg::QUIET_WIDTH-1:0]     o_quiet_level,
    output logic [sbq_pkg::LIMIT_WIDTH-1:0]     o_settle_limit,
    output logic                                o_stereo_enable
);
    import sbq_pkg::*;

    t_coefs                 r_coefs;
    logic [QUIET_WIDTH-1:0] r_quiet;
    logic [LIMIT_WIDTH-1:0] r_limit;
    logic                   r_stereo;
    t_reg_idx               idx;
    logic                   wr_en;

    assign idx    = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_WIDTH'(65536);
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
            r_quiet    <= QUIET_WIDTH'(26);
            r_limit    <= LIMIT_WIDTH'(256);
            r_stereo   <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_COEF_B0:       r_coefs.b0 <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_B1:       r_coefs.b1 <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_B2:       r_coefs.b2 <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_A1:       r_coefs.a1 <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_A2:       r_coefs.a2 <= pwdata[COEF_WIDTH-1:0];
                REG_QUIET_LEVEL:   r_quiet    <= pwdata[QUIET_WIDTH-1:0];
                REG_SETTLE_LIMIT:  r_limit    <= pwdata[LIMIT_WIDTH-1:0];
                REG_STEREO_ENABLE: r_stereo   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_COEF_B0:       prdata = CFG_DATA_W'(unsigned'(r_coefs.b0));
            REG_COEF_B1:       prdata = CFG_DATA_W'(unsigned'(r_coefs.b1));
            REG_COEF_B2:       prdata = CFG_DATA_W'(unsigned'(r_coefs.b2));
            REG_COEF_A1:       prdata = CFG_DATA_W'(unsigned'(r_coefs.a1));
            REG_COEF_A2:       prdata = CFG_DATA_W'(unsigned'(r_coefs.a2));
            REG_QUIET_LEVEL:   prdata = CFG_DATA_W'(r_quiet);
            REG_SETTLE_LIMIT:  prdata = CFG_DATA_W'(r_limit);
            REG_STEREO_ENABLE: prdata = CFG_DATA_W'(r_stereo);
            default:           prdata = '0;
        endcase
    end

    assign o_coefs         = r_coefs;
    assign o_quiet_level   = r_quiet;
    assign o_settle_limit  = r_limit;
    assign o_stereo_enable = r_stereo;

endmodule

`default_nettype wire

FILE: rtl/core/sbq_gate.sv
// ----------------------------------------------------------------------------
// sbq_gate
// Silence detector and idle counter deciding whether a sample is gated.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_gate #(
    parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_fire,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      i_x_left,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      i_x_right,
    input  wire logic                                i_write,
    input  wire logic [sbq_pkg::QUIET_WIDTH-1:0]     i_quiet_level,
    input  wire logic [sbq_pkg::LIMIT_WIDTH-1:0]     i_settle_limit,
    output sbq_pkg::t_step_ctrl                      o_ctrl
);
    import sbq_pkg::*;

    localparam int CMP_W = SAMPLE_WIDTH + QUIET_WIDTH;

    logic [LIMIT_WIDTH-1:0]  r_idle;
    logic [LIMIT_WIDTH-1:0]  n_idle;
    logic [SAMPLE_WIDTH-1:0] mag_l;
    logic [SAMPLE_WIDTH-1:0] mag_r;
    logic                    loud;
    logic                    settled;
    logic                    gated;

    // magnitude of the most negative sample still fits unsigned
    assign mag_l = i_x_left[SAMPLE_WIDTH-1]  ? (~i_x_left + 1'b1)  : i_x_left;
    assign mag_r = i_x_right[SAMPLE_WIDTH-1] ? (~i_x_right + 1'b1) : i_x_right;

    assign loud    = (CMP_W'(mag_l) > CMP_W'(i_quiet_level))
                  || (CMP_W'(mag_r) > CMP_W'(i_quiet_level));
    assign settled = r_idle >= i_settle_limit;
    assign gated   = !loud && settled && i_write;

    always_comb begin
        if (loud) begin
            n_idle = '0;
        end else if (settled) begin
            n_idle = r_idle;
        end else begin
            n_idle = r_idle + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
        end else if (i_fire) begin
            r_idle <= n_idle;
        end
    end

    assign o_ctrl = t_step_ctrl'{run: !gated, zero_out: gated || !i_write};

endmodule

`default_nettype wire

FILE: rtl/core/sbq_chan.sv
// ----------------------------------------------------------------------------
// sbq_chan
// One direct-form-1 biquad channel with its input and output history.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_chan #(
    parameter int SAMPLE_WIDTH   = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_update,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  wire sbq_pkg::t_coefs                i_coefs,
    output logic signed [SAMPLE_WIDTH-1:0]      o_y
);
    import sbq_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 1;

    logic signed [SAMPLE_WIDTH-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [PROD_W-1:0]       p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        scaled;
    logic signed [SAMPLE_WIDTH-1:0] y;

    assign p_b0 = i_x  * i_coefs.b0;
    assign p_b1 = r_x1 * i_coefs.b1;
    assign p_b2 = r_x2 * i_coefs.b2;
    assign p_a1 = r_y1 * i_coefs.a1;
    assign p_a2 = r_y2 * i_coefs.a2;

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2);

    // round half up, then floor shift
    assign scaled = (acc + RND) >>> COEF_FRAC_BITS;

    always_comb begin
        if (scaled > SMAX) begin
            y = SMAX[SAMPLE_WIDTH-1:0];
        end else if (scaled < SMIN) begin
            y = SMIN[SAMPLE_WIDTH-1:0];
        end else begin
            y = scaled[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_update) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
            r_y1 <= y;
            r_y2 <= r_y1;
        end
    end

    assign o_y = y;

endmodule

`default_nettype wire

FILE: rtl/core/stereo_biquad_with_silence_gate.sv
// ----------------------------------------------------------------------------
// stereo_biquad_with_silence_gate
// Result path: input register, then filter and gate logic into the
//   result register.
// Throughput: one sample per cycle unless the result side stalls; the biquad
//   feedback closes combinationally through the five multipliers and adder.
// Reset (synchronous, active low) clears history, idle counter and handshake
//   state, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_biquad_with_silence_gate #(
    parameter int SAMPLE_WIDTH   = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF,
    parameter int TDATA_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [TDATA_W-1:0]             i_s_axis_tdata,  // in_left, in_right
    input  wire logic [1:0]                     i_s_axis_tuser,  // mode
    input  wire logic                           i_s_axis_tlast,  // block_end
    // master side
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [TDATA_W-1:0]                  o_m_axis_tdata,  // out_left, out_right
    output logic                                o_m_axis_tuser,  // write_valid
    output logic                                o_m_axis_tlast,  // last_out
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sbq_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sbq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [sbq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import sbq_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    t_coefs                 coefs;
    logic [QUIET_WIDTH-1:0] quiet_level;
    logic [LIMIT_WIDTH-1:0] settle_limit;
    logic                   stereo;

    // input register
    logic                  r_in_valid;
    logic [1:0]            r_mode;
    logic signed [SW-1:0]  r_in_left;
    logic signed [SW-1:0]  r_in_right;
    logic                  r_in_last;

    // result register
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_out_left;
    logic signed [SW-1:0]  r_out_right;
    logic                  r_out_wr;
    logic                  r_out_last;

    logic                  in_acc;
    logic                  fire;
    logic                  rd;
    logic                  wr;
    logic signed [SW-1:0]  x_left;
    logic signed [SW-1:0]  x_right;
    logic signed [SW-1:0]  y_left;
    logic signed [SW-1:0]  y_right;
    t_step_ctrl            ctrl;

    sbq_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_coefs        (coefs),
        .o_quiet_level  (quiet_level),
        .o_settle_limit (settle_limit),
        .o_stereo_enable(stereo)
    );

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode     <= i_s_axis_tuser;
            r_in_left  <= i_s_axis_tdata[SW-1:0];
            r_in_right <= i_s_axis_tdata[2*SW-1:SW];
            r_in_last  <= i_s_axis_tlast;
        end
    end

    assign rd      = r_mode[0];
    assign wr      = r_mode[1];
    assign x_left  = rd ? r_in_left : '0;
    assign x_right = (rd && stereo) ? r_in_right : '0;

    sbq_gate #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_gate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_x_left      (x_left),
        .i_x_right     (x_right),
        .i_write       (wr),
        .i_quiet_level (quiet_level),
        .i_settle_limit(settle_limit),
        .o_ctrl        (ctrl)
    );

    sbq_chan #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_chan_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_update(fire && ctrl.run),
        .i_x     (x_left),
        .i_coefs (coefs),
        .o_y     (y_left)
    );

    // right history holds while mono
    sbq_chan #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_chan_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_update(fire && ctrl.run && stereo),
        .i_x     (x_right),
        .i_coefs (coefs),
        .o_y     (y_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_left  <= ctrl.zero_out ? '0 : y_left;
            r_out_right <= (ctrl.zero_out || !stereo) ? '0 : y_right;
            r_out_wr    <= wr;
            r_out_last  <= r_in_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_out_right, r_out_left});
    assign o_m_axis_tuser  = r_out_wr;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: dv/biquad_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// biquad_scoreboard_pkg
// Predicts the filtered, gated sample stream of the stereo biquad and checks
// every result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package biquad_scoreboard_pkg;

    import sbq_pkg::*;

    localparam int     SAMPLE_W       = SAMPLE_WIDTH_DEF;
    localparam longint SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN     = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam longint ROUND_HALF     = 64'sd1 <<< (COEF_FRAC_BITS_DEF - 1);
    localparam int     RESULT_LATENCY = 2;
    localparam int     CHAN_LEFT      = 0;
    localparam int     CHAN_RIGHT     = 1;

    // mode field of the input transaction
    localparam logic [1:0] MODE_NONE   = 2'b00;
    localparam logic [1:0] MODE_READ   = 2'b01;
    localparam logic [1:0] MODE_WRITE  = 2'b10;
    localparam logic [1:0] MODE_FILTER = 2'b11;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                write_valid;
        logic                last;
    } t_filtered_sample;

    class filter_scoreboard;
        logic signed [COEF_WIDTH-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
        logic [QUIET_WIDTH-1:0]       quiet_level;
        logic [LIMIT_WIDTH-1:0]       settle_limit;
        logic                         stereo_en;
        logic signed [SAMPLE_W-1:0]   x_hist [2][2];
        logic signed [SAMPLE_W-1:0]   y_hist [2][2];
        logic [LIMIT_WIDTH-1:0]       idle_count;
        t_filtered_sample             expected_q [$];
        int                           errors;

        function new();
            coef_b0      = 20'sd65536;
            coef_b1      = '0;
            coef_b2      = '0;
            coef_a1      = '0;
            coef_a2      = '0;
            quiet_level  = 23'd26;
            settle_limit = 16'd256;
            stereo_en    = 1'b0;
            foreach (x_hist[c, k]) begin
                x_hist[c][k] = '0;
                y_hist[c][k] = '0;
            end
            idle_count = '0;
            errors     = 0;
        endfunction

        task report_mismatch(string msg);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_COEF_B0:       coef_b0      = value[COEF_WIDTH-1:0];
                REG_COEF_B1:       coef_b1      = value[COEF_WIDTH-1:0];
                REG_COEF_B2:       coef_b2      = value[COEF_WIDTH-1:0];
                REG_COEF_A1:       coef_a1      = value[COEF_WIDTH-1:0];
                REG_COEF_A2:       coef_a2      = value[COEF_WIDTH-1:0];
                REG_QUIET_LEVEL:   quiet_level  = value[QUIET_WIDTH-1:0];
                REG_SETTLE_LIMIT:  settle_limit = value[LIMIT_WIDTH-1:0];
                REG_STEREO_ENABLE: stereo_en    = value[0];
                default: ;
            endcase
        endfunction

        function int field_width(t_reg_idx idx);
            case (idx)
                REG_QUIET_LEVEL:   return QUIET_WIDTH;
                REG_SETTLE_LIMIT:  return LIMIT_WIDTH;
                REG_STEREO_ENABLE: return 1;
                default:           return COEF_WIDTH;
            endcase
        endfunction

        function logic [CFG_DATA_W-1:0] reg_value(t_reg_idx idx);
            logic [CFG_DATA_W-1:0] v;
            v = '0;
            case (idx)
                REG_COEF_B0:       v[COEF_WIDTH-1:0]  = coef_b0;
                REG_COEF_B1:       v[COEF_WIDTH-1:0]  = coef_b1;
                REG_COEF_B2:       v[COEF_WIDTH-1:0]  = coef_b2;
                REG_COEF_A1:       v[COEF_WIDTH-1:0]  = coef_a1;
                REG_COEF_A2:       v[COEF_WIDTH-1:0]  = coef_a2;
                REG_QUIET_LEVEL:   v[QUIET_WIDTH-1:0] = quiet_level;
                REG_SETTLE_LIMIT:  v[LIMIT_WIDTH-1:0] = settle_limit;
                REG_STEREO_ENABLE: v[0]               = stereo_en;
                default: ;
            endcase
            return v;
        endfunction

        function longint magnitude(logic signed [SAMPLE_W-1:0] v);
            return (v < 0) ? -longint'(v) : longint'(v);
        endfunction

        // one direct-form-1 step, exact sum then round half up and saturate
        function logic signed [SAMPLE_W-1:0] filter_step(int ch, logic signed [SAMPLE_W-1:0] x);
            longint acc;
            longint y;
            acc = longint'(x) * longint'(coef_b0)
                + longint'(x_hist[ch][0]) * longint'(coef_b1)
                + longint'(x_hist[ch][1]) * longint'(coef_b2)
                - longint'(y_hist[ch][0]) * longint'(coef_a1)
                - longint'(y_hist[ch][1]) * longint'(coef_a2);
            y = (acc + ROUND_HALF) >>> COEF_FRAC_BITS_DEF;
            if (y > SAMPLE_MAX)
                y = SAMPLE_MAX;
            else if (y < SAMPLE_MIN)
                y = SAMPLE_MIN;
            x_hist[ch][1] = x_hist[ch][0];
            x_hist[ch][0] = x;
            y_hist[ch][1] = y_hist[ch][0];
            y_hist[ch][0] = SAMPLE_W'(y);
            return SAMPLE_W'(y);
        endfunction

        function void note_input(logic [1:0] mode, logic signed [SAMPLE_W-1:0] in_l,
                                 logic signed [SAMPLE_W-1:0] in_r, logic blk_end);
            t_filtered_sample           s;
            logic                       rd, wr, loud, gated;
            logic signed [SAMPLE_W-1:0] xl, xr, yl, yr;
            rd    = (mode & MODE_READ) != 0;
            wr    = (mode & MODE_WRITE) != 0;
            xl    = rd ? in_l : '0;
            xr    = (rd && stereo_en) ? in_r : '0;
            loud  = magnitude(xl) > longint'(quiet_level) ||
                    magnitude(xr) > longint'(quiet_level);
            gated = 1'b0;
            yl    = '0;
            yr    = '0;
            if (loud)
                idle_count = '0;
            else if (idle_count >= settle_limit)
                gated = wr;
            else
                idle_count = idle_count + 1'b1;
            if (!gated) begin
                yl = filter_step(CHAN_LEFT, xl);
                if (stereo_en)
                    yr = filter_step(CHAN_RIGHT, xr);
            end
            if (!wr || gated) begin
                yl = '0;
                yr = '0;
            end
            s.left        = yl;
            s.right       = yr;
            s.write_valid = wr;
            s.last        = blk_end;
            expected_q.insert(expected_q.size(), s);
        endfunction

        task check_result(logic [2*SAMPLE_W-1:0] data, logic wr_valid, logic last);
            t_filtered_sample e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, tdata=%h", data));
                return;
            end
            e = expected_q.pop_front();
            if (data[SAMPLE_W-1:0] !== e.left)
                report_mismatch($sformatf("out_left %h, expected %h",
                                          data[SAMPLE_W-1:0], e.left));
            if (data[2*SAMPLE_W-1:SAMPLE_W] !== e.right)
                report_mismatch($sformatf("out_right %h, expected %h",
                                          data[2*SAMPLE_W-1:SAMPLE_W], e.right));
            if (wr_valid !== e.write_valid)
                report_mismatch($sformatf("write_valid %b, expected %b",
                                          wr_valid, e.write_valid));
            if (last !== e.last)
                report_mismatch($sformatf("last_out %b, expected %b", last, e.last));
        endtask
    endclass

endpackage

FILE: dv/stereo_biquad_with_silence_gate_test.sv
// ----------------------------------------------------------------------------
// stereo_biquad_with_silence_gate_test
// Drives directed and random sample streams through the biquad under many
// coefficient, quiet level, settle and stereo settings, with random idling on
// both stream sides, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module stereo_biquad_with_silence_gate_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sbq_pkg::*;
    import biquad_scoreboard_pkg::*;

    localparam int TDATA_W     = 2 * SAMPLE_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 12;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    wire                   o_s_axis_tready;
    logic [TDATA_W-1:0]    i_s_axis_tdata  = '0;   // in_left, in_right
    logic [1:0]            i_s_axis_tuser  = '0;   // mode
    logic                  i_s_axis_tlast  = 1'b0; // block_end
    wire                   o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    wire [TDATA_W-1:0]     o_m_axis_tdata;         // out_left, out_right
    wire                   o_m_axis_tuser;         // write_valid
    wire                   o_m_axis_tlast;         // last_out
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr           = '0;
    logic [CFG_DATA_W-1:0] pwdata          = '0;
    wire  [CFG_DATA_W-1:0] prdata;
    wire                   pready;

    filter_scoreboard sb;
    int               idle_pct    = 38;
    int               cycle_count = 0;

    stereo_biquad_with_silence_gate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
    end

    task automatic send_sample(input logic [1:0] mode, input logic signed [SAMPLE_W-1:0] left,
                               input logic signed [SAMPLE_W-1:0] right, input logic blk_end);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {right, left};
        i_s_axis_tuser  <= mode;
        i_s_axis_tlast  <= blk_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(mode, left, right, blk_end);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // write, then read back and compare the implemented bits
    task automatic set_register(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mask = (CFG_DATA_W'(1) << sb.field_width(idx)) - 1'b1;
        if ((prdata & mask) !== sb.reg_value(idx))
            sb.report_mismatch($sformatf("register %s reads %h, expected %h",
                                         idx.name(), prdata & mask, sb.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure_filter(input int b0, input int b1, input int b2, input int a1,
                                    input int a2, input int quiet, input int settle,
                                    input bit stereo);
        set_register(REG_COEF_B0, CFG_DATA_W'(b0));
        set_register(REG_COEF_B1, CFG_DATA_W'(b1));
        set_register(REG_COEF_B2, CFG_DATA_W'(b2));
        set_register(REG_COEF_A1, CFG_DATA_W'(a1));
        set_register(REG_COEF_A2, CFG_DATA_W'(a2));
        set_register(REG_QUIET_LEVEL, CFG_DATA_W'(quiet));
        set_register(REG_SETTLE_LIMIT, CFG_DATA_W'(settle));
        set_register(REG_STEREO_ENABLE, CFG_DATA_W'(stereo));
    endtask

    function automatic int signed_range(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] quiet_sample(int q);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? SAMPLE_W'(q) : SAMPLE_W'(-q);
        return SAMPLE_W'(signed_range(q));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] loud_sample(int q);
        int m;
        int top;
        // with the widest quiet level only the most negative sample is loud
        if (q >= SAMPLE_MAX || $urandom_range(0, 15) == 0)
            return SAMPLE_W'(SAMPLE_MIN);
        top = (q + 2000 > SAMPLE_MAX) ? int'(SAMPLE_MAX) : q + 2000;
        m   = $urandom_range(0, 1) ? int'($urandom_range(q + 1, int'(SAMPLE_MAX)))
                                   : int'($urandom_range(q + 1, top));
        return $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    task automatic configure_phase(input int ph);
        int c[5];
        int quiet;
        int settle;
        case (ph % 3)
            0: begin
                c[0] = $urandom_range(8192, 65536);
                c[1] = signed_range(32768);
                c[2] = signed_range(32768);
                c[3] = signed_range(65536);
                c[4] = $urandom_range(0, 49152);
            end
            1: begin
                c[0] = 65536;
                c[1] = signed_range(8192);
                c[2] = signed_range(8192);
                c[3] = 0;
                c[4] = 0;
            end
            default: begin
                foreach (c[i])
                    c[i] = $urandom;
            end
        endcase
        case (ph % 4)
            0:       quiet = 0;
            1:       quiet = $urandom_range(0, 64);
            2:       quiet = $urandom_range(0, 200000);
            default: quiet = (ph == 3) ? int'(SAMPLE_MAX) : 26;
        endcase
        if (ph == 4)
            settle = 256;
        else if (ph == 7)
            settle = 65535;
        else
            case (ph % 3)
                0:       settle = 0;
                1:       settle = $urandom_range(1, 4);
                default: settle = $urandom_range(5, 24);
            endcase
        configure_filter(c[0], c[1], c[2], c[3], c[4], quiet, settle, ph % 2);
    endtask

    // runs of silence, some of them long enough to settle the gate, broken by loud bursts
    task automatic run_random_phase(input int target);
        int   sent;
        int   run_len;
        int   q;
        int   s;
        bit   silent;
        logic [1:0] mode;
        logic signed [SAMPLE_W-1:0] l, r, t;
        sent = 0;
        q    = int'(sb.quiet_level);
        s    = int'(sb.settle_limit);
        while (sent < target) begin
            silent = ($urandom_range(0, 99) < 55);
            if (!silent)
                run_len = $urandom_range(1, 12);
            else if ($urandom_range(0, 1) == 0)
                run_len = ((s > 300) ? 300 : s) + $urandom_range(1, 6);
            else
                run_len = $urandom_range(1, (s > 300) ? 300 : s + 6);
            repeat (run_len) begin
                mode = ($urandom_range(0, 99) < 75) ? MODE_FILTER : 2'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    l = SAMPLE_W'($urandom);
                    r = SAMPLE_W'($urandom);
                end else if (silent) begin
                    l = quiet_sample(q);
                    r = sb.stereo_en ? quiet_sample(q) : SAMPLE_W'($urandom);
                end else begin
                    l = loud_sample(q);
                    r = SAMPLE_W'($urandom);
                    if (sb.stereo_en && $urandom_range(0, 1)) begin
                        t = l;
                        l = r;
                        r = t;
                    end
                end
                send_sample(mode, l, r, $urandom_range(0, 15) == 0);
                sent++;
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unity gain, mono
        send_sample(MODE_FILTER, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN), 1'b0);
        send_sample(MODE_FILTER, SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX), 1'b1);
        send_sample(MODE_FILTER, 24'sd26, 24'sd0, 1'b0);
        send_sample(MODE_FILTER, -24'sd27, 24'sd0, 1'b0);
        send_sample(MODE_WRITE, 24'sd12345, 24'sd0, 1'b0);
        send_sample(MODE_READ, 24'sd5000, 24'sd0, 1'b0);
        send_sample(MODE_NONE, 24'sd100, 24'sd100, 1'b0);
        send_sample(MODE_FILTER, 24'sd0, -24'sd1, 1'b1);
        drain_results();

        // extreme coefficients, gate from the first silent sample
        configure_filter(524287, -524288, 524287, -524288, 524287, 0, 0, 1'b1);
        send_sample(MODE_FILTER, 24'sd1, 24'sd0, 1'b0);
        send_sample(MODE_FILTER, 24'sd0, -24'sd1, 1'b0);
        send_sample(MODE_FILTER, 24'sd0, 24'sd0, 1'b0);
        send_sample(MODE_READ, 24'sd0, 24'sd0, 1'b0);
        send_sample(MODE_WRITE, 24'sd0, 24'sd0, 1'b0);
        send_sample(MODE_FILTER, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN), 1'b1);
        send_sample(MODE_FILTER, SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX), 1'b0);
        send_sample(MODE_NONE, SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MIN), 1'b0);
        drain_results();

        // mono, short settle, quiet level boundary
        configure_filter(-524288, 0, 0, 0, 0, 100, 2, 1'b0);
        send_sample(MODE_FILTER, 24'sd100, SAMPLE_W'(SAMPLE_MAX), 1'b0);
        send_sample(MODE_FILTER, -24'sd100, SAMPLE_W'(SAMPLE_MIN), 1'b0);
        send_sample(MODE_FILTER, 24'sd50, 24'sd0, 1'b0);
        send_sample(MODE_FILTER, 24'sd101, 24'sd0, 1'b0);
        send_sample(MODE_FILTER, 24'sd0, 24'sd0, 1'b1);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure_phase(ph);
            idle_pct = (ph == 5) ? 0 : 38;
            run_random_phase((ph == 4) ? 360 : 115);
            drain_results();
        end
        idle_pct = 38;

        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
